/* hw/rtl/igs_pkg.sv */
// shared types, stream layout and sigmoid table function for the ising gibbs sampler
`default_nettype none
package igs_pkg;

  localparam int KIND_W   = 3;
  localparam int CHAIN_W  = 2;
  localparam int SITE_W   = 6;
  localparam int WEIGHT_W = 16;
  localparam int PROB_W   = 16;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_BIAS     = 3'd0,
    KIND_COUPLING = 3'd1,
    KIND_SPIN     = 3'd2,
    KIND_UPDATE   = 3'd3,
    KIND_READ     = 3'd4
  } kind_e;

  localparam longint unsigned ONE_Q32    = 64'd4294967296;
  localparam longint unsigned EXP_M1_Q32 = 64'd1580030169;

  // restoring shift and subtract quotient, used only while building the table
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned dvs);
    longint unsigned q;
    longint unsigned rem;
    q   = 0;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | ((num >> b) & 64'd1);
      if (rem >= dvs) begin
        rem = rem - dvs;
        q   = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  // sigmoid(2h) in q0.16 for a bin center hc given in q4.12
  function automatic logic [PROB_W-1:0] sig_entry(input longint hc);
    longint unsigned a;
    longint unsigned y;
    longint unsigned ip;
    longint unsigned f;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned r;
    longint unsigned den;
    longint unsigned dv;
    longint unsigned p;
    a    = (hc < 0) ? longint'(-hc) : longint'(hc);
    y    = 2 * a;
    ip   = y >> 12;
    f    = (y & 64'hFFF) << 4;
    term = ONE_Q32;
    pos  = ONE_Q32;
    neg  = 0;
    // taylor series of e^-x on the fraction, each term truncated
    for (int n = 1; n <= 13; n++) begin
      dv   = longint'(n) << 16;
      term = udiv64(term * f, dv);
      if ((n % 2) == 1) neg = neg + term;
      else pos = pos + term;
    end
    r = pos - neg;
    for (longint unsigned i = 0; i < ip; i++) begin
      r = (r * EXP_M1_Q32) >> 32;
    end
    den = ONE_Q32 + r;
    if (hc < 0) p = udiv64((r << 16) + (den >> 1), den);
    else p = udiv64((ONE_Q32 << 16) + (den >> 1), den);
    if (p > 64'd65535) p = 64'd65535;
    return p[PROB_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/igs_ram.sv */
// generic single write port, single read port ram with registered read
`default_nettype none
module igs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/igs_sig_rom.sv */
// sigmoid(2h) lookup table with registered read
`default_nettype none
module igs_sig_rom #(
  parameter int ENTRIES = 1024
) (
  input  wire logic                       clk_i,
  input  wire logic                       re_i,
  input  wire logic [$clog2(ENTRIES)-1:0] addr_i,
  output logic      [igs_pkg::PROB_W-1:0] data_o
);
  import igs_pkg::*;

  logic [PROB_W-1:0] tbl [ENTRIES];

  for (genvar k = 0; k < ENTRIES; k++) begin : g_entry
    // bin center in q4.12
    localparam longint Hc = longint'(((2 * k + 1) * 32768) / ENTRIES) - 64'sd32768;
    localparam logic [PROB_W-1:0] Val = sig_entry(Hc);
    assign tbl[k] = Val;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      data_o <= tbl[addr_i];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ising_gibbs_spin_update.sv */
// Ising gibbs sampler: stores, local field accumulator and spin decision
// A load is written on acceptance and the block stays idle; a read passes ST_RD and ST_RDOUT.
// An update passes ST_ACC once per site, then ST_LAST, ST_CLAMP, ST_LOOK and ST_DEC. The
// next item is taken once the result word has been loaded into the output register.
// The update time is set by the coupling and spin memories, one site per cycle.
// One item is worked on at a time; a finished word waits in the output register.
// Reset clears the control state only; the stores hold nothing until loaded.
`default_nettype none
module ising_gibbs_spin_update #(
  parameter int NUM_SITES       = 64,
  parameter int NUM_CHAINS      = 4,
  parameter int WEIGHT_BITS     = 16,
  parameter int SIGMOID_ENTRIES = 1024
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // chain, site, column, weight_value, spin_value, random_uniform, zero pad
  input  wire logic [igs_pkg::IN_W-1:0]    s_axis_tdata,
  // kind
  input  wire logic [igs_pkg::KIND_W-1:0]  s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // out_chain, out_site, out_spin, probability, zero pad
  output logic      [igs_pkg::OUT_W-1:0]   m_axis_tdata
);
  import igs_pkg::*;

  localparam int SITE_AW  = $clog2(NUM_SITES);
  localparam int CHAIN_AW = (NUM_CHAINS > 1) ? $clog2(NUM_CHAINS) : 1;
  localparam int CP_AW    = $clog2(NUM_SITES * NUM_SITES);
  localparam int SP_AW    = $clog2(NUM_CHAINS * NUM_SITES);
  localparam int RA_W     = $clog2(SIGMOID_ENTRIES);
  localparam int ACC_W    = WEIGHT_W + 1 + $clog2(NUM_SITES + 1);
  localparam int HB       = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
  localparam int PROD_W   = WEIGHT_W + $clog2(SIGMOID_ENTRIES + 1);
  localparam int KI_W     = PROD_W - WEIGHT_W;

  localparam logic signed [ACC_W-1:0] HMAX = ACC_W'((1 << (HB - 1)) - 1);
  localparam logic signed [ACC_W-1:0] HMIN = ACC_W'(-(1 << (HB - 1)));

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ACC   = 3'd1;
  localparam logic [2:0] ST_LAST  = 3'd2;
  localparam logic [2:0] ST_CLAMP = 3'd3;
  localparam logic [2:0] ST_LOOK  = 3'd4;
  localparam logic [2:0] ST_DEC   = 3'd5;
  localparam logic [2:0] ST_RD    = 3'd6;
  localparam logic [2:0] ST_RDOUT = 3'd7;

  // input word unpack
  logic [CHAIN_W-1:0]  in_chain;
  logic [SITE_W-1:0]   in_site;
  logic [SITE_W-1:0]   in_column;
  logic [WEIGHT_W-1:0] in_weight;
  logic                in_spin;
  logic [PROB_W-1:0]   in_random;
  kind_e               in_kind;

  assign in_chain  = s_axis_tdata[1:0];
  assign in_site   = s_axis_tdata[7:2];
  assign in_column = s_axis_tdata[13:8];
  assign in_weight = s_axis_tdata[29:14];
  assign in_spin   = s_axis_tdata[30];
  assign in_random = s_axis_tdata[46:31];
  assign in_kind   = kind_e'(s_axis_tuser);

  logic [2:0]                state_q, state_d;
  logic [SITE_AW-1:0]        cnt_q, cnt_d;
  logic                      rv_q, first_q;
  logic                      m_valid_q;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [WEIGHT_W-1:0] h_q;
  logic [CHAIN_W-1:0]        chain_q;
  logic [SITE_W-1:0]         site_q;
  logic [SITE_AW-1:0]        site_idx_q;
  logic [PROB_W-1:0]         u_q;
  logic [SP_AW-1:0]          chain_base_q;
  logic [CP_AW-1:0]          row_base_q;
  logic [CHAIN_W-1:0]        out_chain_q;
  logic [SITE_W-1:0]         out_site_q;
  logic                      out_spin_q;
  logic [PROB_W-1:0]         out_prob_q;

  logic in_fire, site_ok, chain_ok, col_ok;
  logic [SITE_AW-1:0]  in_site_idx, in_col_idx;
  logic [CHAIN_AW-1:0] in_chain_idx;
  logic [SP_AW-1:0]    in_chain_base;
  logic [CP_AW-1:0]    in_row_base;
  logic out_free, out_load;
  logic out_spin_d;
  logic [PROB_W-1:0] out_prob_d;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign site_ok       = 32'(in_site) < NUM_SITES;
  assign col_ok        = 32'(in_column) < NUM_SITES;
  assign chain_ok      = 32'(in_chain) < NUM_CHAINS;
  assign in_site_idx   = SITE_AW'(in_site);
  assign in_col_idx    = SITE_AW'(in_column);
  assign in_chain_idx  = CHAIN_AW'(in_chain);
  assign in_chain_base = SP_AW'(in_chain_idx) * SP_AW'(NUM_SITES);
  assign in_row_base   = CP_AW'(in_site_idx) * CP_AW'(NUM_SITES);
  assign out_free      = !m_valid_q || m_axis_tready;

  // memories
  logic                 bias_we, cp_we, sp_we;
  logic [SITE_AW-1:0]   bias_waddr;
  logic [CP_AW-1:0]     cp_waddr, cp_raddr;
  logic [SP_AW-1:0]     sp_waddr, sp_raddr;
  logic                 sp_wdata;
  logic                 acc_re, sp_re;
  logic [WEIGHT_W-1:0]  bias_rdata, cp_rdata;
  logic                 sp_rdata;
  logic [RA_W-1:0]      rom_addr;
  logic [PROB_W-1:0]    rom_data;

  assign bias_we    = in_fire && (in_kind == KIND_BIAS) && site_ok;
  assign bias_waddr = in_site_idx;
  assign cp_we      = in_fire && (in_kind == KIND_COUPLING) && site_ok && col_ok;
  assign cp_waddr   = in_row_base + CP_AW'(in_col_idx);
  assign acc_re     = (state_q == ST_ACC);
  assign cp_raddr   = row_base_q + CP_AW'(cnt_q);
  assign sp_re      = acc_re || (state_q == ST_RD);
  assign sp_raddr   = chain_base_q + SP_AW'(acc_re ? cnt_q : site_idx_q);

  always_comb begin
    sp_we    = 1'b0;
    sp_waddr = in_chain_base + SP_AW'(in_site_idx);
    sp_wdata = in_spin;
    if (in_fire && (in_kind == KIND_SPIN) && site_ok && chain_ok) begin
      sp_we = 1'b1;
    end else if ((state_q == ST_DEC) && out_free) begin
      // write back the decided spin
      sp_we    = 1'b1;
      sp_waddr = chain_base_q + SP_AW'(site_idx_q);
      sp_wdata = out_spin_d;
    end
  end

  igs_ram #(.WIDTH(WEIGHT_W), .DEPTH(NUM_SITES)) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (bias_we),
    .waddr_i (bias_waddr),
    .wdata_i (in_weight),
    .re_i    (acc_re),
    .raddr_i (site_idx_q),
    .rdata_o (bias_rdata)
  );

  igs_ram #(.WIDTH(WEIGHT_W), .DEPTH(NUM_SITES * NUM_SITES)) u_coupling_ram (
    .clk_i   (clk_i),
    .we_i    (cp_we),
    .waddr_i (cp_waddr),
    .wdata_i (in_weight),
    .re_i    (acc_re),
    .raddr_i (cp_raddr),
    .rdata_o (cp_rdata)
  );

  igs_ram #(.WIDTH(1), .DEPTH(NUM_CHAINS * NUM_SITES)) u_spin_ram (
    .clk_i   (clk_i),
    .we_i    (sp_we),
    .waddr_i (sp_waddr),
    .wdata_i (sp_wdata),
    .re_i    (sp_re),
    .raddr_i (sp_raddr),
    .rdata_o (sp_rdata)
  );

  igs_sig_rom #(.ENTRIES(SIGMOID_ENTRIES)) u_sig_rom (
    .clk_i  (clk_i),
    .re_i   (state_q == ST_LOOK),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  // field accumulation, one site per cycle
  logic signed [ACC_W-1:0] acc_base, w_ext;
  always_comb begin
    acc_base = first_q ? ACC_W'(signed'(bias_rdata)) : acc_q;
    w_ext    = ACC_W'(signed'(cp_rdata));
    acc_d    = acc_q;
    if (rv_q) begin
      acc_d = sp_rdata ? (acc_base + w_ext) : (acc_base - w_ext);
    end
  end

  // saturate to the weight width and to q4.12
  logic signed [ACC_W-1:0] acc_sat;
  always_comb begin
    acc_sat = acc_q;
    if (acc_q > HMAX) acc_sat = HMAX;
    if (acc_q < HMIN) acc_sat = HMIN;
  end

  // table index from the offset field
  logic [WEIGHT_W-1:0] h_off;
  logic [PROD_W-1:0]   prod;
  logic [KI_W-1:0]     kidx;
  always_comb begin
    h_off = {~h_q[WEIGHT_W-1], h_q[WEIGHT_W-2:0]};
    prod  = PROD_W'(h_off) * PROD_W'(SIGMOID_ENTRIES);
    kidx  = prod[PROD_W-1:WEIGHT_W];
    if (32'(kidx) >= SIGMOID_ENTRIES) kidx = KI_W'(SIGMOID_ENTRIES - 1);
    rom_addr = RA_W'(kidx);
  end

  assign out_spin_d = (state_q == ST_DEC) ? (u_q < rom_data) : sp_rdata;
  assign out_prob_d = (state_q == ST_DEC) ? rom_data : '0;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_fire && site_ok && chain_ok) begin
          if (in_kind == KIND_UPDATE) state_d = ST_ACC;
          else if (in_kind == KIND_READ) state_d = ST_RD;
        end
      end
      ST_ACC: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SITE_AW'(NUM_SITES - 1)) state_d = ST_LAST;
      end
      ST_LAST:  state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_LOOK;
      ST_LOOK:  state_d = ST_DEC;
      ST_DEC: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_RD:    state_d = ST_RDOUT;
      ST_RDOUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      rv_q      <= 1'b0;
      first_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rv_q    <= acc_re;
      first_q <= acc_re && (cnt_q == '0);
      if (out_load) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (state_q == ST_CLAMP) h_q <= WEIGHT_W'(acc_sat);
    if (in_fire) begin
      chain_q      <= in_chain;
      site_q       <= in_site;
      site_idx_q   <= in_site_idx;
      u_q          <= in_random;
      chain_base_q <= in_chain_base;
      row_base_q   <= in_row_base;
    end
    if (out_load) begin
      out_chain_q <= chain_q;
      out_site_q  <= site_q;
      out_spin_q  <= out_spin_d;
      out_prob_q  <= out_prob_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, out_prob_q, out_spin_q, out_site_q, out_chain_q};

  // spin store is written only by a load in idle or by the update decision
  a_spin_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_we |-> (state_q == ST_IDLE) || (state_q == ST_DEC))
    else $error("spin store written outside load or decision");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC) |-> (32'(cnt_q) < NUM_SITES))
    else $error("site counter out of range");

  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("pending result overwritten");

  a_last_read_accum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LAST) |-> rv_q)
    else $error("final coupling word not accumulated");

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// self-checking testbench for the ising gibbs sampler: loads, updates and reads on random streams
`timescale 1ns / 100ps
module tb_top;
  import igs_pkg::*;

  localparam int NUM_SITES   = 64;
  localparam int NUM_CHAINS  = 4;
  localparam int SIG_ENTRIES = 1024;
  localparam int RANDOM_WORDS = 1100;
  localparam int QUIET_FROM   = 1000;
  localparam int DRAIN_CYCLES = 2 * NUM_SITES;

  localparam logic [KIND_W-1:0]   KIND_UNUSED_FIRST = 3'd5;
  localparam logic [KIND_W-1:0]   KIND_UNUSED_LAST  = 3'd7;
  localparam logic [WEIGHT_W-1:0] W_MAX  = 16'h7FFF;
  localparam logic [WEIGHT_W-1:0] W_MIN  = 16'h8000;
  localparam logic [WEIGHT_W-1:0] W_ZERO = 16'h0000;
  localparam logic [PROB_W-1:0]   U_MAX  = 16'hFFFF;
  localparam logic [PROB_W-1:0]   U_ZERO = 16'h0000;
  localparam logic [PROB_W-1:0]   U_HALF = 16'h8000;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [CHAIN_W-1:0]  chain;
    logic [SITE_W-1:0]   site;
    logic [SITE_W-1:0]   column;
    logic [WEIGHT_W-1:0] weight;
    logic                spin;
    logic [PROB_W-1:0]   rnd;
  } word_t;

  typedef struct packed {
    logic [CHAIN_W-1:0] chain;
    logic [SITE_W-1:0]  site;
    logic               spin;
    logic [PROB_W-1:0]  prob;
  } spin_result_t;

  // keeps its own copy of the stores and the sigmoid table, predicts every spin word
  class spin_scoreboard;
    logic signed [WEIGHT_W-1:0] bias_w [NUM_SITES];
    logic signed [WEIGHT_W-1:0] coup_w [NUM_SITES*NUM_SITES];
    bit                         spins  [NUM_CHAINS*NUM_SITES];
    logic [PROB_W-1:0]          prob_rom [SIG_ENTRIES];
    spin_result_t               expected_q [$];
    int                         failures;

    function new();
      int center;
      int unsigned mag;
      longint unsigned ex;
      longint unsigned den;
      longint unsigned p;
      failures = 0;
      foreach (bias_w[i]) bias_w[i] = '0;
      foreach (coup_w[i]) coup_w[i] = '0;
      foreach (spins[i]) spins[i] = 1'b0;
      for (int k = 0; k < SIG_ENTRIES; k++) begin
        center = ((2 * k + 1) * 32768) / SIG_ENTRIES - 32768;
        mag = (center < 0) ? -center : center;
        ex = exp_neg(2 * mag);
        den = ONE_Q32 + ex;
        if (center < 0) p = ((ex << 16) + den / 2) / den;
        else p = ((ONE_Q32 << 16) + den / 2) / den;
        if (p > 65535) p = 65535;
        prob_rom[k] = p[PROB_W-1:0];
      end
    endfunction

    // e^-y in q0.32 for y in q12: truncated taylor terms on the fraction, then e^-1 per unit
    function longint unsigned exp_neg(int unsigned y_q12);
      longint unsigned frac;
      longint unsigned term;
      longint unsigned sum_even;
      longint unsigned sum_odd;
      longint unsigned acc;
      frac = longint'(y_q12 % 4096) * 16;
      term = ONE_Q32;
      sum_even = ONE_Q32;
      sum_odd = 0;
      for (int n = 1; n <= 13; n++) begin
        term = (term * frac) / (longint'(n) * 65536);
        if (n % 2 == 1) sum_odd += term;
        else sum_even += term;
      end
      acc = sum_even - sum_odd;
      for (int unsigned i = 0; i < y_q12 / 4096; i++) acc = (acc * EXP_M1_Q32) >> 32;
      return acc;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_word(logic [IN_W-1:0] d, logic [KIND_W-1:0] kind);
      logic [CHAIN_W-1:0]  chain;
      logic [SITE_W-1:0]   site;
      logic [SITE_W-1:0]   column;
      logic [WEIGHT_W-1:0] weight;
      logic                spin;
      logic [PROB_W-1:0]   rnd;
      int                  field;
      int                  idx;
      spin_result_t        res;
      chain  = d[1:0];
      site   = d[7:2];
      column = d[13:8];
      weight = d[29:14];
      spin   = d[30];
      rnd    = d[46:31];
      case (kind)
        KIND_BIAS:     bias_w[site] = weight;
        KIND_COUPLING: coup_w[site*NUM_SITES + column] = weight;
        KIND_SPIN:     spins[chain*NUM_SITES + site] = spin;
        KIND_UPDATE: begin
          field = int'(bias_w[site]);
          for (int j = 0; j < NUM_SITES; j++) begin
            if (spins[chain*NUM_SITES + j]) field += int'(coup_w[site*NUM_SITES + j]);
            else field -= int'(coup_w[site*NUM_SITES + j]);
          end
          if (field > 32767) field = 32767;
          if (field < -32768) field = -32768;
          idx = ((field + 32768) * SIG_ENTRIES) >> 16;
          res.chain = chain;
          res.site  = site;
          res.prob  = prob_rom[idx];
          res.spin  = (rnd < res.prob);
          spins[chain*NUM_SITES + site] = res.spin;
          expected_q.push_back(res);
        end
        KIND_READ: begin
          res.chain = chain;
          res.site  = site;
          res.spin  = spins[chain*NUM_SITES + site];
          res.prob  = '0;
          expected_q.push_back(res);
        end
        default: ;  // unused kinds are dropped by the block
      endcase
    endfunction

    function void check_word(logic [OUT_W-1:0] d);
      spin_result_t want;
      if (expected_q.size() == 0) begin
        $error("spin word with nothing expected: %h", d);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      if (d[1:0] !== want.chain) begin
        $error("out_chain: expected %0d, got %0d", want.chain, d[1:0]);
        failures++;
      end
      if (d[7:2] !== want.site) begin
        $error("out_site: expected %0d, got %0d", want.site, d[7:2]);
        failures++;
      end
      if (d[8] !== want.spin) begin
        $error("out_spin: expected %0d, got %0d", want.spin, d[8]);
        failures++;
      end
      if (d[24:9] !== want.prob) begin
        $error("probability: expected %0d, got %0d", want.prob, d[24:9]);
        failures++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;
  logic [KIND_W-1:0] s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;

  spin_scoreboard sb;
  bit quiet;
  int in_busy;

  ising_gibbs_spin_update #(
    .NUM_SITES      (NUM_SITES),
    .NUM_CHAINS     (NUM_CHAINS),
    .WEIGHT_BITS    (WEIGHT_W),
    .SIGMOID_ENTRIES(SIG_ENTRIES)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // mostly small weights so the field lands inside the sigmoid, some full range and extremes
  function automatic logic [WEIGHT_W-1:0] pick_weight();
    int v;
    case ($urandom_range(0, 7))
      0: return WEIGHT_W'($urandom);
      1: return ($urandom_range(0, 1) != 0) ? W_MAX : W_MIN;
      default: begin
        v = int'($urandom_range(0, 2046)) - 1023;
        return v[WEIGHT_W-1:0];
      end
    endcase
  endfunction

  function automatic word_t any_word(logic [KIND_W-1:0] kind);
    word_t w;
    w.kind   = kind;
    w.chain  = CHAIN_W'($urandom);
    w.site   = SITE_W'($urandom);
    w.column = SITE_W'($urandom);
    w.weight = pick_weight();
    w.spin   = 1'($urandom);
    w.rnd    = PROB_W'($urandom);
    return w;
  endfunction

  // rows 0..2 saturate high, saturate low and sit at zero field when all their spins are up
  function automatic logic [WEIGHT_W-1:0] row_weight(int row);
    case (row)
      0: return W_MAX;
      1: return W_MIN;
      2: return W_ZERO;
      default: return pick_weight();
    endcase
  endfunction

  task automatic push_word(word_t w);
    if (in_busy != 0 && $urandom_range(0, 7) < in_busy) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 16)) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= w.kind;
    s_axis_tdata  <= {1'b0, w.rnd, w.spin, w.weight, w.column, w.site, w.chain};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic push_spin_op(logic [KIND_W-1:0] kind, int chain, int site,
                              logic [PROB_W-1:0] rnd);
    word_t w;
    w = any_word(kind);
    w.chain = chain[CHAIN_W-1:0];
    w.site  = site[SITE_W-1:0];
    w.rnd   = rnd;
    push_word(w);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_word(s_axis_tdata, s_axis_tuser);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
  end

  // result side back-pressure
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      if (quiet) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 16)) @(negedge clk_i);
      end else begin
        @(negedge clk_i);
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(0, 15)) @(negedge clk_i);
      end
    end
  end

  initial begin
    #8000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    word_t w;
    int    done;
    int    pick;
    sb = new();
    quiet = 1'b0;
    in_busy = 1;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = KIND_BIAS;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // every store entry gets written before anything reads it
    for (int s = 0; s < NUM_SITES; s++) begin
      w = any_word(KIND_BIAS);
      w.site = s[SITE_W-1:0];
      w.weight = row_weight(s);
      push_word(w);
    end
    for (int r = 0; r < NUM_SITES; r++) begin
      for (int c = 0; c < NUM_SITES; c++) begin
        w = any_word(KIND_COUPLING);
        w.site = r[SITE_W-1:0];
        w.column = c[SITE_W-1:0];
        w.weight = row_weight(r);
        push_word(w);
      end
    end
    for (int ch = 0; ch < NUM_CHAINS; ch++) begin
      for (int s = 0; s < NUM_SITES; s++) begin
        w = any_word(KIND_SPIN);
        w.chain = ch[CHAIN_W-1:0];
        w.site = s[SITE_W-1:0];
        // chain 0 all up, chain 1 all down
        w.spin = (ch == 0) ? 1'b1 : (ch == 1) ? 1'b0 : 1'($urandom);
        push_word(w);
      end
    end

    // directed corners
    in_busy = 2;
    push_spin_op(KIND_UPDATE, 0, 0, U_MAX);   // top probability with the top draw stays down
    push_spin_op(KIND_READ, 0, 0, U_ZERO);
    push_spin_op(KIND_UPDATE, 0, 1, U_ZERO);  // field saturated low
    push_spin_op(KIND_UPDATE, 1, 1, U_MAX - 1);
    push_spin_op(KIND_UPDATE, 1, 0, U_MAX);
    push_spin_op(KIND_UPDATE, 2, 2, U_HALF);  // zero field, near one half
    push_spin_op(KIND_UPDATE, 3, 2, U_ZERO);
    w = any_word(KIND_BIAS);
    w.site = SITE_W'(NUM_SITES - 1);
    w.weight = W_MIN;
    push_word(w);
    w = any_word(KIND_COUPLING);
    w.site = SITE_W'(NUM_SITES - 1);
    w.column = SITE_W'(NUM_SITES - 1);
    w.weight = W_MAX;
    push_word(w);
    w = any_word(KIND_SPIN);
    w.chain = CHAIN_W'(NUM_CHAINS - 1);
    w.site = SITE_W'(NUM_SITES - 1);
    w.spin = 1'b0;
    push_word(w);
    w.site = SITE_W'(NUM_SITES - 2);
    w.spin = 1'b1;
    push_word(w);
    push_spin_op(KIND_READ, NUM_CHAINS - 1, NUM_SITES - 1, U_MAX);
    push_spin_op(KIND_UPDATE, NUM_CHAINS - 1, NUM_SITES - 1, PROB_W'($urandom));
    push_spin_op(KIND_READ, NUM_CHAINS - 1, NUM_SITES - 2, U_ZERO);
    for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++) begin
      w = any_word(k[KIND_W-1:0]);
      push_word(w);
    end
    push_spin_op(KIND_READ, 0, 1, U_ZERO);
    push_spin_op(KIND_READ, 2, 2, U_ZERO);

    done = 0;
    while (done < RANDOM_WORDS) begin
      if (done % 50 == 0) in_busy = $urandom_range(0, 3);
      quiet = (done >= QUIET_FROM);
      if (quiet) in_busy = 0;
      pick = $urandom_range(0, 99);
      if (pick < 30) w = any_word(KIND_UPDATE);
      else if (pick < 45) w = any_word(KIND_READ);
      else if (pick < 55) w = any_word(KIND_BIAS);
      else if (pick < 80) w = any_word(KIND_COUPLING);
      else if (pick < 92) w = any_word(KIND_SPIN);
      else w = any_word(KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST)));
      push_word(w);
      if (pick < 92) done++;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* ising_gibbs_spin_update.f */
hw/rtl/igs_pkg.sv
hw/rtl/igs_ram.sv
hw/rtl/igs_sig_rom.sv
hw/rtl/ising_gibbs_spin_update.sv
tb/tb_top.sv
